@@ design/dss_pkg.sv @@
`default_nettype none
package dss_pkg;

  // digit code map: 0..9 digits, then letter P, then blank
  localparam logic [3:0] CODE_P     = 4'd10;
  localparam logic [3:0] CODE_BLANK = 4'd11;

  localparam logic [19:0] MAX_SHOWN  = 20'd999999;
  localparam int          BIN_W      = 20;
  localparam int          NUM_DIGITS = 6;
  localparam int          NUM_POS    = 8;
  localparam logic [7:0]  ALL_OFF    = 8'hFF;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture value, clear converter
    logic conv_step;   // one shift-add-3 step
    logic store;       // write blanked digit codes
    logic scan_start;  // rewind scan position
    logic emit;        // present one scan item
  } dss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;   // final conversion step in progress
    logic scan_last;   // all-off item being emitted
  } dss_sts_t;

  // active-low segment byte per code, unused codes are all off
  function automatic logic [7:0] seg_lookup(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      CODE_P:  seg = 8'h8C;
      default: seg = ALL_OFF;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

@@ design/dss_ctrl.sv @@
`default_nettype none
module dss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_kind,
  input  wire dss_pkg::dss_sts_t sts,
  output dss_pkg::dss_cmd_t      cmd,
  output logic                   busy
);
  import dss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CONV  = 4'b0010,
    S_STORE = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_kind) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.emit = 1'b1;
        if (sts.scan_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTHESIS
  // a store always follows the last conversion step
  a_store_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.conv_step && sts.conv_done) |=> cmd.store)
    else $error("store did not follow conversion");
  // commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("overlapping datapath commands");
`endif

endmodule
`default_nettype wire

@@ design/dss_datapath.sv @@
`default_nettype none
module dss_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dss_pkg::dss_cmd_t cmd,
  input  wire logic [19:0]       in_frequency_value,
  output dss_pkg::dss_sts_t      sts,
  output logic                   out_valid,
  output logic [7:0]             out_position_select,
  output logic [7:0]             out_segment_pattern,
  output logic                   out_last
);
  import dss_pkg::*;

  // double-dabble converter state
  logic [BIN_W-1:0]        bin_r;
  logic [4*NUM_DIGITS-1:0] bcd_r, bcd_adj;
  logic [4:0]              bit_cnt_r;
  // digit codes for positions 2..7
  logic [3:0]              codes_r [NUM_DIGITS];
  logic [3:0]              codes_nxt [NUM_DIGITS];
  logic [3:0]              pos_code [NUM_POS];
  // scan position 0..8, 8 is the all-off item
  logic [3:0]              pos_r;
  logic                    out_valid_r, out_last_r;
  logic [7:0]              out_pos_r, out_seg_r;
  logic [BIN_W-1:0]        sat_value;

  assign sat_value = (in_frequency_value > MAX_SHOWN) ? MAX_SHOWN : in_frequency_value;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      else                         bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r     <= sat_value;
      bcd_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.conv_step) begin
      {bcd_r, bin_r} <= {bcd_adj[4*NUM_DIGITS-2:0], bin_r, 1'b0};
      bit_cnt_r      <= bit_cnt_r + 5'd1;
    end
  end

  assign sts.conv_done = (bit_cnt_r == 5'(BIN_W - 1));

  // leading-zero blanking, most significant digit first; last digit always shown
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*(NUM_DIGITS-1-i) +: 4] != 4'd0 || i == NUM_DIGITS - 1) seen = 1'b1;
      codes_nxt[i] = seen ? bcd_r[4*(NUM_DIGITS-1-i) +: 4] : CODE_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) codes_r[i] <= CODE_BLANK;
    end else if (cmd.store) begin
      for (int i = 0; i < NUM_DIGITS; i++) codes_r[i] <= codes_nxt[i];
    end
  end

  // full position view: P, blank, then stored digits
  always_comb begin
    pos_code[0] = CODE_P;
    pos_code[1] = CODE_BLANK;
    for (int i = 0; i < NUM_DIGITS; i++) pos_code[i+2] = codes_r[i];
  end

  // scan position counter
  always_ff @(posedge clk) begin
    if (cmd.scan_start)  pos_r <= '0;
    else if (cmd.emit)   pos_r <= pos_r + 4'd1;
  end

  assign sts.scan_last = (pos_r == 4'(NUM_POS));

  // registered result item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      out_last_r  <= cmd.emit && sts.scan_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (sts.scan_last) begin
        out_pos_r <= ALL_OFF;
        out_seg_r <= ALL_OFF;
      end else begin
        out_pos_r <= 8'd1 << pos_r[2:0];
        out_seg_r <= seg_lookup(pos_code[pos_r[2:0]]);
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_last            = out_last_r;
  assign out_position_select = out_pos_r;
  assign out_segment_pattern = out_seg_r;

`ifndef SYNTHESIS
  // last item is always a valid one
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last without valid");
  // a scan's last item is never directly followed by another item
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_valid)
    else $error("item right after last");
  // regular scan items select exactly one position
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> $onehot(out_position_select))
    else $error("position select not one-hot");
`endif

endmodule
`default_nettype wire

@@ design/decimal_seven_segment_scan.sv @@
// Load item: busy for 20 shift-add-3 steps and the digit store, no results;
// a new item is taken only once the block is back in idle.
// Refresh item: 9 result items on consecutive cycles, each registered from one scan state;
// busy for the whole scan, which moves on one position per cycle; the next item waits for idle.
// The receiver cannot stall; out_valid marks each item for one cycle.
// Synchronous active-low reset: idle, no items pending, display shows P then blanks.
`default_nettype none
module decimal_seven_segment_scan (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [19:0] in_frequency_value,
  output logic             out_valid,
  output logic [7:0]       out_position_select,
  output logic [7:0]       out_segment_pattern,
  output logic             out_last
);
  import dss_pkg::*;

  dss_cmd_t cmd;
  dss_sts_t sts;

  dss_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  dss_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_frequency_value  (in_frequency_value),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_position_select (out_position_select),
    .out_segment_pattern (out_segment_pattern),
    .out_last            (out_last)
  );

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int IDLE_MAX      = 14;
  localparam int RANDOM_ITEMS  = 156;
  localparam int CALM_TAIL     = 30;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 30;
  localparam int REPORT_MAX    = 10;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REFRESH = 1'b1;

  // segment bytes per digit code, code 0 in the low byte; codes 11..15 all off
  localparam logic [127:0] SEG_BYTES = {{5{8'hFF}}, 8'h8C, 8'h90, 8'h80, 8'hF8, 8'h82,
                                        8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

  // typed-in scan patterns, position 0 in the low byte
  localparam logic [63:0] SEGS_RESET = 64'hFFFF_FFFF_FFFF_FF8C;
  localparam logic [63:0] SEGS_ZERO  = 64'hC0FF_FFFF_FFFF_FF8C;
  localparam logic [63:0] SEGS_NINES = 64'h9090_9090_9090_FF8C;

  typedef struct packed {
    logic [7:0] sel;
    logic [7:0] seg;
    logic       fin;
  } scan_item_t;

  typedef struct packed {
    logic        kind;
    logic [19:0] value;
    logic        typed;
    logic [63:0] segs;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_kind = 1'b0;
  logic [19:0] in_frequency_value = '0;
  logic        busy;
  logic        out_valid;
  logic [7:0]  out_position_select;
  logic [7:0]  out_segment_pattern;
  logic        out_last;

  decimal_seven_segment_scan dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_frequency_value  (in_frequency_value),
    .out_valid           (out_valid),
    .out_position_select (out_position_select),
    .out_segment_pattern (out_segment_pattern),
    .out_last            (out_last)
  );

  always #5 clk = ~clk;

  logic [3:0]  shown_codes [NUM_POS];
  scan_item_t  pending_scan_q [$];
  stim_row_t   directed_rows [$];
  scan_item_t  want;
  int          err_count = 0;
  int          idle_pct = 0;
  bit          calm = 1'b0;

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endtask

  // display state after reset: P then blanks
  task automatic clear_display();
    shown_codes[0] = CODE_P;
    for (int p = 1; p < NUM_POS; p++) shown_codes[p] = CODE_BLANK;
  endtask

  // binary to six decimal digits on positions 2..7, leading zeros blanked
  task automatic load_display_value(input logic [19:0] raw);
    int v;
    int d [6];
    bit seen;
    v = int'(raw);
    if (v > int'(MAX_SHOWN)) v = int'(MAX_SHOWN);
    for (int i = 5; i >= 0; i--) begin
      d[i] = v % 10;
      v = v / 10;
    end
    seen = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (d[i] != 0 || i == 5) seen = 1'b1;
      shown_codes[2 + i] = seen ? 4'(d[i]) : CODE_BLANK;
    end
    shown_codes[0] = CODE_P;
    shown_codes[1] = CODE_BLANK;
  endtask

  // one refresh: eight positions, then the all-off item marked last
  task automatic queue_refresh_scan(input bit typed, input logic [63:0] segs);
    scan_item_t it;
    for (int p = 0; p < NUM_POS; p++) begin
      it.sel = 8'(1 << p);
      it.seg = typed ? segs[p*8 +: 8] : SEG_BYTES[int'(shown_codes[p])*8 +: 8];
      it.fin = 1'b0;
      pending_scan_q.push_back(it);
    end
    it.sel = ALL_OFF;
    it.seg = ALL_OFF;
    it.fin = 1'b1;
    pending_scan_q.push_back(it);
  endtask

  // optional idle burst, then hold start until the block takes the item
  task automatic send_item(input logic kind, input logic [19:0] value,
                           input bit typed, input logic [63:0] segs);
    int gap;
    if (!calm && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, IDLE_MAX);
      start <= 1'b0;
      in_kind <= 1'($urandom);
      in_frequency_value <= 20'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_frequency_value <= value;
    do @(posedge clk); while (busy);
    if (kind == KIND_LOAD) load_display_value(value);
    else queue_refresh_scan(typed, segs);
  endtask

  // value with a random digit count, sometimes past saturation or fully random
  function automatic logic [19:0] rand_value();
    int n;
    int lo;
    int hi;
    if ($urandom_range(5) == 0) return 20'($urandom);
    n = $urandom_range(1, 7);
    lo = (n == 1) ? 0 : 10 ** (n - 1);
    hi = (n == 7) ? 20'hFFFFF : 10 ** n - 1;
    return 20'($urandom_range(hi, lo));
  endfunction

  task automatic add_row(input logic kind, input logic [19:0] value,
                         input bit typed, input logic [63:0] segs);
    stim_row_t r;
    r.kind = kind;
    r.value = value;
    r.typed = typed;
    r.segs = segs;
    directed_rows.push_back(r);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_scan_q.size() == 0) begin
        note_error($sformatf("unexpected scan item sel=%02h seg=%02h last=%0b",
                             out_position_select, out_segment_pattern, out_last));
      end else begin
        want = pending_scan_q.pop_front();
        if (out_position_select !== want.sel || out_segment_pattern !== want.seg ||
            out_last !== want.fin)
          note_error($sformatf({"scan item mismatch: exp sel=%02h seg=%02h last=%0b, ",
                                "got sel=%02h seg=%02h last=%0b"},
                               want.sel, want.seg, want.fin, out_position_select,
                               out_segment_pattern, out_last));
      end
    end
  end

  // stimulus
  initial begin
    int n;
    logic kind;

    clear_display();

    // directed: reset view, zero, saturation, blanking, ignored value on refresh
    add_row(KIND_REFRESH, 20'd0,       1'b1, SEGS_RESET);
    add_row(KIND_REFRESH, 20'hFFFFF,   1'b1, SEGS_RESET);
    add_row(KIND_LOAD,    20'd0,       1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b1, SEGS_ZERO);
    add_row(KIND_LOAD,    20'd999999,  1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b1, SEGS_NINES);
    add_row(KIND_LOAD,    20'hFFFFF,   1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b1, SEGS_NINES);
    add_row(KIND_LOAD,    20'd1000000, 1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b1, SEGS_NINES);
    add_row(KIND_LOAD,    20'd1,       1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b0, '0);
    add_row(KIND_LOAD,    20'd10,      1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b0, '0);
    add_row(KIND_LOAD,    20'd100000,  1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b0, '0);
    add_row(KIND_LOAD,    20'd123456,  1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b0, '0);
    add_row(KIND_LOAD,    20'd5,       1'b0, '0);
    add_row(KIND_LOAD,    20'd908070,  1'b0, '0);
    add_row(KIND_REFRESH, 20'h5A5A5,   1'b0, '0);
    add_row(KIND_LOAD,    20'd999,     1'b0, '0);
    add_row(KIND_REFRESH, 20'd0,       1'b0, '0);
    add_row(KIND_REFRESH, 20'hAAAAA,   1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 25;
    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].segs);

    // random: mostly refreshes, idle density changes every 20 items, calm tail
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 30;
          default: idle_pct = 70;
        endcase
      end
      calm = (i >= RANDOM_ITEMS - CALM_TAIL);
      kind = ($urandom_range(99) < 35) ? KIND_LOAD : KIND_REFRESH;
      send_item(kind, rand_value(), 1'b0, '0);
    end
    start <= 1'b0;

    // drain, then let a trailing load finish
    n = 0;
    while (pending_scan_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_scan_q.size() != 0)
      note_error($sformatf("%0d scan items never arrived", pending_scan_q.size()));

    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
design/dss_pkg.sv
design/dss_ctrl.sv
design/dss_datapath.sv
design/decimal_seven_segment_scan.sv
dv/tb.sv
